>>> rtl/nale_pkg.sv
// ----------------------------------------------------------------------------
// nale_pkg
// Types and fixed constants shared by the nonce ARQ link engine and its
// per-peer nonce table.
// ----------------------------------------------------------------------------
package nale_pkg;

  // Peer table geometry: one row per 8-bit peer address
  localparam int unsigned TBL_AW    = 8;
  localparam int unsigned TBL_DEPTH = 1 << TBL_AW;

  // Frame layout constants
  localparam int unsigned HDR_LEN   = 5;   // type byte plus nonce
  localparam int unsigned ACKF_LEN  = 10;  // type byte plus two nonces plus pad

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_AW    = 1;

  // Reset values of the configuration registers
  localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd10;
  localparam logic [15:0] RETRY_INTERVAL_RST = 16'd50;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RETRY_LIMIT    = 1'b0,
    CFG_RETRY_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_RADIO = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MSG_DATA = 2'd0,
    MSG_ACK  = 2'd1,
    MSG_NACK = 2'd2
  } msg_kind_e;

  typedef enum logic [3:0] {
    OUT_RADIO_ACK  = 4'd0,
    OUT_RADIO_NACK = 4'd1,
    OUT_RADIO_DATA = 4'd2,
    OUT_HOST_RX    = 4'd3,
    OUT_HOST_SENT  = 4'd4,
    OUT_BUSY       = 4'd5,
    OUT_BAD_ADDR   = 4'd6,
    OUT_BAD_SIZE   = 4'd7,
    OUT_TIMEOUT    = 4'd8
  } out_kind_e;

  // Input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  peer_addr;
    logic [1:0]  msg_kind;
    logic [31:0] msg_nonce;
    logic [31:0] msg_next_nonce;
    logic [6:0]  frame_len;
    logic [6:0]  payload_len;
    logic [7:0]  link_rssi;
    logic [31:0] fresh_nonce;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [3:0]  out_kind;
    logic [7:0]  out_addr;
    logic [31:0] out_nonce_a;
    logic [31:0] out_nonce_b;
    logic [7:0]  out_rssi;
    logic [6:0]  out_len;
    logic        out_last;
  } out_item_t;

  // One peer's row of the nonce table
  typedef struct packed {
    logic [31:0] old_rx;
    logic [31:0] next_rx;
    logic [31:0] tx;
  } nonce_row_t;

  localparam nonce_row_t ROW_RESET = '{old_rx: 32'd0, next_rx: 32'd1, tx: 32'd0};

endpackage

>>> rtl/nale_nonce_tbl.sv
// ----------------------------------------------------------------------------
// nale_nonce_tbl
// Per-peer nonce table: single-port-write, single-port-read synchronous
// memory with a registered read. A valid bit per row stands in for the
// reset contents; a row never written reads as the reset row.
// ----------------------------------------------------------------------------
module nale_nonce_tbl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [nale_pkg::TBL_AW-1:0] rd_addr_i,
  output nale_pkg::nonce_row_t       rd_row_o,
  input  logic                       wr_en_i,
  input  logic [nale_pkg::TBL_AW-1:0] wr_addr_i,
  input  nale_pkg::nonce_row_t       wr_row_i
);

  nale_pkg::nonce_row_t                 mem_q [nale_pkg::TBL_DEPTH];
  nale_pkg::nonce_row_t                 rd_q;
  logic [nale_pkg::TBL_DEPTH-1:0]       vld_q;
  logic                                 rd_vld_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Row valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : nale_pkg::ROW_RESET;

endmodule

>>> rtl/nonce_arq_link_engine.sv
// ----------------------------------------------------------------------------
// nonce_arq_link_engine
// Stop-and-wait link engine with a per-peer nonce table, one send in flight
// and timed retries.
// ----------------------------------------------------------------------------
// The accept cycle reads the peer's table row (the send destination's for
// ticks); the execute step then checks nonces, writes the row back and loads
// the first result once the output register is free. A nack that triggers a
// resend to a peer other than its sender needs a second table read and the
// S_TX2 step. Results leave one per cycle while out_stall_i is low, from an
// output register backed by one pending slot; a new item is taken once any
// second result has moved into the output register. The table has one valid
// bit per row, so no clearing pass runs after reset. Items do not overlap,
// given the table's single read port and one row read-modify-write per item.
// ----------------------------------------------------------------------------
module nonce_arq_link_engine #(
  parameter int unsigned MAX_FRAME = 64,
  parameter int unsigned MIN_PEER  = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [nale_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [nale_pkg::CFG_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nale_pkg::in_item_t            in_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nale_pkg::out_item_t           out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_TX2  = 3'b100
  } state_e;

  localparam logic [7:0] MinPeer     = 8'(MIN_PEER);
  localparam logic [7:0] MaxFrame    = 8'(MAX_FRAME);
  localparam logic [7:0] MaxPayload  = 8'(MAX_FRAME - nale_pkg::HDR_LEN);
  localparam logic [6:0] HdrLen      = 7'(nale_pkg::HDR_LEN);
  localparam logic [6:0] AckFrameLen = 7'(nale_pkg::ACKF_LEN);

  state_e                 state_q, state_d;
  nale_pkg::in_item_t     req_q;
  logic [3:0]             retry_limit_q;
  logic [15:0]            retry_interval_q;
  logic [3:0]             retries_q, retries_d;
  logic [7:0]             dest_q, dest_d;
  logic [6:0]             send_len_q, send_len_d;
  logic [15:0]            ticks_q, ticks_d;

  nale_pkg::out_item_t    out_q, pend_q;
  logic                   out_vld_q, pend_vld_q;
  nale_pkg::out_item_t    res0, res1;
  logic [1:0]             n_res;

  logic                   in_accept, out_free, step_go, tx2_go;
  logic                   tbl_rd_en, tbl_we;
  logic [nale_pkg::TBL_AW-1:0] tbl_rd_addr;
  nale_pkg::nonce_row_t   row, wr_row;
  logic [6:0]             flen_c;
  logic [15:0]            ticks_inc;
  logic [3:0]             retries_dec;
  logic [31:0]            fresh_c;
  logic                   need_tx2;

  function automatic nale_pkg::out_item_t mk_res(nale_pkg::out_kind_e kind,
                                                 logic [7:0] addr,
                                                 logic [31:0] na,
                                                 logic [31:0] nb,
                                                 logic [7:0] rssi,
                                                 logic [6:0] len,
                                                 logic last);
    nale_pkg::out_item_t r;
    r.out_kind    = kind;
    r.out_addr    = addr;
    r.out_nonce_a = na;
    r.out_nonce_b = nb;
    r.out_rssi    = rssi;
    r.out_len     = len;
    r.out_last    = last;
    return r;
  endfunction

  // Handshakes
  assign in_stall_o = !((state_q == S_IDLE) && !pend_vld_q);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step_go    = (state_q == S_EXEC) && out_free;
  assign tx2_go     = (state_q == S_TX2) && out_free;

  // Table read: peer row on accept (send destination row for ticks), else resend target
  always_comb begin
    tbl_rd_en   = in_accept || (step_go && need_tx2);
    tbl_rd_addr = dest_q;
    if (in_accept && (in_i.req_type != nale_pkg::REQ_TICK)) begin
      tbl_rd_addr = in_i.peer_addr;
    end
  end

  nale_nonce_tbl u_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (tbl_rd_addr),
    .rd_row_o  (row),
    .wr_en_i   (tbl_we && step_go),
    .wr_addr_i (req_q.peer_addr),
    .wr_row_i  (wr_row)
  );

  // Helper values for the execute step
  assign flen_c      = ({1'b0, req_q.frame_len} > MaxFrame) ? MaxFrame[6:0]
                                                            : req_q.frame_len;
  assign ticks_inc   = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
  assign retries_dec = retries_q - 4'd1;
  assign fresh_c     = (req_q.fresh_nonce == row.next_rx)
                       ? {req_q.fresh_nonce[31:1], ~req_q.fresh_nonce[0]}
                       : req_q.fresh_nonce;

  // Execute step: nonce checks, row update, send state and results
  always_comb begin
    res0       = '0;
    res1       = '0;
    n_res      = 2'd0;
    tbl_we     = 1'b0;
    wr_row     = row;
    retries_d  = retries_q;
    dest_d     = dest_q;
    send_len_d = send_len_q;
    ticks_d    = ticks_q;
    need_tx2   = 1'b0;
    case (req_q.req_type)
      nale_pkg::REQ_RADIO: begin
        if (req_q.peer_addr >= MinPeer) begin
          case (req_q.msg_kind)
            nale_pkg::MSG_DATA: begin
              if (req_q.frame_len >= HdrLen) begin
                if (req_q.msg_nonce == row.old_rx) begin
                  // duplicate: ack again, nothing to host
                  res0  = mk_res(nale_pkg::OUT_RADIO_ACK, req_q.peer_addr,
                                 req_q.msg_nonce, row.next_rx, req_q.link_rssi,
                                 7'd0, 1'b1);
                  n_res = 2'd1;
                end else if (req_q.msg_nonce != row.next_rx) begin
                  res0  = mk_res(nale_pkg::OUT_RADIO_NACK, req_q.peer_addr,
                                 req_q.msg_nonce, row.next_rx, req_q.link_rssi,
                                 7'd0, 1'b1);
                  n_res = 2'd1;
                end else begin
                  // fresh message: roll the receive nonces
                  tbl_we         = 1'b1;
                  wr_row.old_rx  = row.next_rx;
                  wr_row.next_rx = fresh_c;
                  res0  = mk_res(nale_pkg::OUT_RADIO_ACK, req_q.peer_addr,
                                 req_q.msg_nonce, fresh_c, req_q.link_rssi,
                                 7'd0, 1'b0);
                  res1  = mk_res(nale_pkg::OUT_HOST_RX, req_q.peer_addr,
                                 32'd0, 32'd0, 8'd0, flen_c - HdrLen, 1'b1);
                  n_res = 2'd2;
                end
              end
            end
            nale_pkg::MSG_ACK, nale_pkg::MSG_NACK: begin
              if ((req_q.frame_len == AckFrameLen) &&
                  (req_q.msg_nonce == row.tx)) begin
                tbl_we    = 1'b1;
                wr_row.tx = req_q.msg_next_nonce;
                if (req_q.msg_kind == nale_pkg::MSG_ACK) begin
                  retries_d  = 4'd0;
                  send_len_d = 7'd0;
                  res0  = mk_res(nale_pkg::OUT_HOST_SENT, req_q.peer_addr,
                                 32'd0, 32'd0, 8'd0, 7'd0, 1'b1);
                  n_res = 2'd1;
                end else if (retries_q != 4'd0) begin
                  if (req_q.peer_addr == dest_q) begin
                    ticks_d = 16'd0;
                    res0  = mk_res(nale_pkg::OUT_RADIO_DATA, dest_q,
                                   req_q.msg_next_nonce, 32'd0, 8'd0,
                                   send_len_q, 1'b1);
                    n_res = 2'd1;
                  end else begin
                    need_tx2 = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      nale_pkg::REQ_SEND: begin
        n_res = 2'd1;
        if (req_q.peer_addr < MinPeer) begin
          res0 = mk_res(nale_pkg::OUT_BAD_ADDR, req_q.peer_addr, 32'd0, 32'd0,
                        8'd0, 7'd0, 1'b1);
        end else if ({1'b0, req_q.payload_len} > MaxPayload) begin
          res0 = mk_res(nale_pkg::OUT_BAD_SIZE, req_q.peer_addr, 32'd0, 32'd0,
                        8'd0, 7'd0, 1'b1);
        end else if (retries_q != 4'd0) begin
          res0 = mk_res(nale_pkg::OUT_BUSY, req_q.peer_addr, 32'd0, 32'd0,
                        8'd0, 7'd0, 1'b1);
        end else begin
          dest_d     = req_q.peer_addr;
          send_len_d = req_q.payload_len;
          retries_d  = retry_limit_q;
          ticks_d    = 16'd0;
          res0 = mk_res(nale_pkg::OUT_RADIO_DATA, req_q.peer_addr, row.tx,
                        32'd0, 8'd0, req_q.payload_len, 1'b1);
        end
      end
      nale_pkg::REQ_TICK: begin
        if (retries_q != 4'd0) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= retry_interval_q) begin
            retries_d = retries_dec;
            n_res     = 2'd1;
            if (retries_dec == 4'd0) begin
              send_len_d = 7'd0;
              res0 = mk_res(nale_pkg::OUT_TIMEOUT, dest_q, 32'd0, 32'd0,
                            8'd0, 7'd0, 1'b1);
            end else begin
              ticks_d = 16'd0;
              res0 = mk_res(nale_pkg::OUT_RADIO_DATA, dest_q, row.tx, 32'd0,
                            8'd0, send_len_q, 1'b1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (step_go) begin
          state_d = need_tx2 ? S_TX2 : S_IDLE;
        end
      end
      S_TX2: begin
        if (tx2_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Captured item
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_i;
    end
  end

  // Control state, configuration and send state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      retry_limit_q    <= nale_pkg::RETRY_LIMIT_RST;
      retry_interval_q <= nale_pkg::RETRY_INTERVAL_RST;
      retries_q        <= 4'd0;
      dest_q           <= 8'd0;
      send_len_q       <= 7'd0;
      ticks_q          <= 16'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nale_pkg::CFG_RETRY_LIMIT:    retry_limit_q    <= cfg_wdata_i[3:0];
          nale_pkg::CFG_RETRY_INTERVAL: retry_interval_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (step_go) begin
        retries_q  <= retries_d;
        dest_q     <= dest_d;
        send_len_q <= send_len_d;
        ticks_q    <= ticks_d;
      end else if (tx2_go) begin
        ticks_q <= 16'd0;
      end
    end
  end

  // Output register and pending slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (step_go && (n_res != 2'd0)) begin
        out_vld_q  <= 1'b1;
        pend_vld_q <= (n_res == 2'd2);
      end else if (tx2_go) begin
        out_vld_q <= 1'b1;
      end else if (pend_vld_q && out_free) begin
        out_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && (n_res != 2'd0)) begin
      out_q  <= res0;
      pend_q <= res1;
    end else if (tx2_go) begin
      out_q <= mk_res(nale_pkg::OUT_RADIO_DATA, dest_q, row.tx, 32'd0, 8'd0,
                      send_len_q, 1'b1);
    end else if (pend_vld_q && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // Checks
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> out_vld_q)
    else $error("pending result without a held output");

  a_pend_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> !out_q.out_last)
    else $error("first of two results flagged as last");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted item did not enter the execute step");

  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.out_kind == nale_pkg::OUT_TIMEOUT)) |-> (retries_q == 4'd0))
    else $error("timeout reported while a send is still in flight");

endmodule
